### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the suppression unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define ENMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define ENMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hw/rtl/enms_pkg.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression package
// Widths, geometry limits, codes and stage types of the suppression unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package enms_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int RING_SIZE = 2 * MAX_WIDTH + 4;
    localparam int RING_AW   = $clog2(RING_SIZE);
    localparam int SUM_W     = RING_AW + 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = COL_W + 1;
    localparam int M_W       = WIDTH_W + 1;
    localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W     = 16;
    localparam int MAG_W     = 8;
    localparam int DIR_W     = 2;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // normal direction codes
    localparam logic [DIR_W-1:0] DIR_HORZ    = 2'd0;  // left / right
    localparam logic [DIR_W-1:0] DIR_DIAG_DN = 2'd1;  // up-left / down-right
    localparam logic [DIR_W-1:0] DIR_VERT    = 2'd2;  // up / down
    localparam logic [DIR_W-1:0] DIR_DIAG_UP = 2'd3;  // up-right / down-left

    typedef struct packed {
        logic [RING_AW-1:0] slot;
        logic               top;
        logic               bottom;
        logic               left;
        logic               right;
        logic               row_end;
        logic               frame_end;
    } t_s1;

    typedef struct packed {
        logic [MAG_W-1:0] center;
        logic             a_ok;
        logic             b_ok;
        logic             row_end;
        logic             frame_end;
    } t_s2;

endpackage

`default_nettype wire

### hw/rtl/enms_if.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression channels
// Valid/ready interfaces for pixel input, edge output and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface enms_pix_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [enms_pkg::MAG_W-1:0]  magnitude;
    logic [enms_pkg::DIR_W-1:0]  direction;

    modport source (output valid, action, magnitude, direction, input ready);
    modport sink   (input valid, action, magnitude, direction, output ready);
endinterface

interface enms_edge_if;
    logic                        valid;
    logic                        ready;
    logic [enms_pkg::MAG_W-1:0]  edge_value;
    logic                        row_end;
    logic                        frame_end;

    modport source (output valid, edge_value, row_end, frame_end, input ready);
    modport sink   (input valid, edge_value, row_end, frame_end, output ready);
endinterface

interface enms_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [enms_pkg::CFG_IDX_W-1:0]   index;
    logic [enms_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/edge_non_maximum_suppression_unit.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression unit
// Pixel ring in two line memories; center and neighbors fetched in two steps.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled, limited by the
//   single write port of the rings. A release reads the center into s1, the
//   neighbors into s2 and the compare result into the output register; pixels are
//   released image_width + 1 pixel transfers late, flush transfers drain the rest.
// Reset: counters and stage valids clear, geometry returns to 640 x 480;
//   the line memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edge_non_maximum_suppression_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    enms_pix_if.sink     i_pix,
    enms_cfg_if.sink     i_cfg,
    enms_edge_if.source  o_edge
);

    // geometry
    logic [enms_pkg::WIDTH_W-1:0] r_eff_w, n_eff_w;
    logic [enms_pkg::IMG_H_W-1:0] r_eff_h, n_eff_h;

    // stream position
    logic [enms_pkg::RING_AW-1:0] r_write_slot, n_write_slot;
    logic [enms_pkg::RING_AW-1:0] r_read_slot, n_read_slot;
    logic [enms_pkg::PEND_W-1:0]  r_pending, n_pending;
    logic [enms_pkg::COL_W-1:0]   r_in_col, n_in_col;
    logic [enms_pkg::ROW_W-1:0]   r_in_row, n_in_row;
    logic [enms_pkg::COL_W-1:0]   r_out_col, n_out_col;
    logic [enms_pkg::ROW_W-1:0]   r_out_row, n_out_row;

    // line memories
    logic [enms_pkg::MAG_W+enms_pkg::DIR_W-1:0] r_ctr_ram [enms_pkg::RING_SIZE];
    logic [enms_pkg::MAG_W-1:0]                 r_nb_ram  [enms_pkg::RING_SIZE];

    logic [enms_pkg::MAG_W-1:0] r_ctr_mag;
    logic [enms_pkg::DIR_W-1:0] r_ctr_dir;
    logic [enms_pkg::MAG_W-1:0] r_nb_a, r_nb_b;

    // stages
    logic              r_s1_valid, r_s2_valid, r_out_valid;
    enms_pkg::t_s1     r_s1, n_s1;
    enms_pkg::t_s2     r_s2, n_s2;
    logic [enms_pkg::MAG_W-1:0] r_out_value;
    logic              r_out_row_end, r_out_frame_end;

    logic in_acc, pix_acc, flush_acc, cfg_acc, emit;
    logic s1_adv, s2_adv, out_free;
    logic in_col_last, out_col_last, out_row_last;
    logic [enms_pkg::M_W-1:0]     nb_m;
    logic                         nb_a_ok, nb_b_ok;
    logic [enms_pkg::SUM_W-1:0]   slot_x, m_x, a_sum, b_sum;
    logic [enms_pkg::RING_AW-1:0] a_addr, b_addr;
    logic [enms_pkg::MAG_W-1:0]   a_val, b_val;
    logic                         keep;

    // handshakes
    assign out_free    = !r_out_valid || o_edge.ready;
    assign s2_adv      = r_s2_valid && out_free;
    assign s1_adv      = r_s1_valid && (!r_s2_valid || s2_adv);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign i_cfg.ready = 1'b1;

    assign in_acc    = i_pix.valid && i_pix.ready;
    assign pix_acc   = in_acc && (i_pix.action == enms_pkg::ACT_PIXEL);
    assign flush_acc = in_acc && (i_pix.action == enms_pkg::ACT_FLUSH);
    assign cfg_acc   = i_cfg.valid && i_cfg.ready;

    assign o_edge.valid      = r_out_valid;
    assign o_edge.edge_value = r_out_value;
    assign o_edge.row_end    = r_out_row_end;
    assign o_edge.frame_end  = r_out_frame_end;

    // configuration
    always_comb begin
        n_eff_w = r_eff_w;
        n_eff_h = r_eff_h;
        if (cfg_acc && (i_cfg.index == enms_pkg::CFG_IMAGE_WIDTH)) begin
            if (i_cfg.data[enms_pkg::IMG_W_W-1:0] == '0) begin
                n_eff_w = enms_pkg::WIDTH_W'(1);
            end else if (32'(i_cfg.data[enms_pkg::IMG_W_W-1:0]) > enms_pkg::MAX_WIDTH) begin
                n_eff_w = enms_pkg::WIDTH_W'(enms_pkg::MAX_WIDTH);
            end else begin
                n_eff_w = enms_pkg::WIDTH_W'(i_cfg.data[enms_pkg::IMG_W_W-1:0]);
            end
        end
        if (cfg_acc && (i_cfg.index == enms_pkg::CFG_IMAGE_HEIGHT)) begin
            if (i_cfg.data[enms_pkg::IMG_H_W-1:0] == '0) begin
                n_eff_h = enms_pkg::IMG_H_W'(1);
            end else begin
                n_eff_h = i_cfg.data[enms_pkg::IMG_H_W-1:0];
            end
        end
    end

    // stream position and release decision
    always_comb begin
        in_col_last  = (32'(r_in_col) + 1) >= 32'(r_eff_w);
        out_col_last = (32'(r_out_col) + 1) >= 32'(r_eff_w);
        out_row_last = (32'(r_out_row) + 1) >= 32'(r_eff_h);

        emit = (pix_acc && (32'(r_pending) > 32'(r_eff_w))) ||
               (flush_acc && (r_pending != '0) && (r_in_col == '0) && (r_in_row == '0));

        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_pending    = r_pending;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;

        if (pix_acc) begin
            n_write_slot = (32'(r_write_slot) == enms_pkg::RING_SIZE - 1) ?
                           '0 : r_write_slot + 1'b1;
            if (in_col_last) begin
                n_in_col = '0;
                n_in_row = ((32'(r_in_row) + 1) >= 32'(r_eff_h)) ? '0 : r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (!emit) begin
                n_pending = r_pending + 1'b1;
            end
        end else if (emit) begin
            n_pending = r_pending - 1'b1;
        end

        if (emit) begin
            n_read_slot = (32'(r_read_slot) == enms_pkg::RING_SIZE - 1) ?
                          '0 : r_read_slot + 1'b1;
            if (out_col_last) begin
                n_out_col = '0;
                n_out_row = out_row_last ? '0 : r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end

        n_s1.slot      = r_read_slot;
        n_s1.top       = (r_out_row == '0);
        n_s1.bottom    = out_row_last;
        n_s1.left      = (r_out_col == '0);
        n_s1.right     = out_col_last;
        n_s1.row_end   = out_col_last;
        n_s1.frame_end = out_col_last && out_row_last;
    end

    // neighbor addresses along the normal
    always_comb begin
        case (r_ctr_dir)
            enms_pkg::DIR_HORZ: begin
                nb_m    = enms_pkg::M_W'(1);
                nb_a_ok = !r_s1.left;
                nb_b_ok = !r_s1.right;
            end
            enms_pkg::DIR_DIAG_DN: begin
                nb_m    = enms_pkg::M_W'(r_eff_w) + enms_pkg::M_W'(1);
                nb_a_ok = !r_s1.top && !r_s1.left;
                nb_b_ok = !r_s1.bottom && !r_s1.right;
            end
            enms_pkg::DIR_VERT: begin
                nb_m    = enms_pkg::M_W'(r_eff_w);
                nb_a_ok = !r_s1.top;
                nb_b_ok = !r_s1.bottom;
            end
            enms_pkg::DIR_DIAG_UP: begin
                nb_m    = enms_pkg::M_W'(r_eff_w) - enms_pkg::M_W'(1);
                nb_a_ok = !r_s1.top && !r_s1.right;
                nb_b_ok = !r_s1.bottom && !r_s1.left;
            end
            default: begin
                nb_m    = '0;
                nb_a_ok = 1'b0;
                nb_b_ok = 1'b0;
            end
        endcase

        slot_x = enms_pkg::SUM_W'(r_s1.slot);
        m_x    = enms_pkg::SUM_W'(nb_m);
        a_sum  = (slot_x >= m_x) ? slot_x - m_x :
                 slot_x + enms_pkg::SUM_W'(enms_pkg::RING_SIZE) - m_x;
        b_sum  = slot_x + m_x;
        if (b_sum >= enms_pkg::SUM_W'(enms_pkg::RING_SIZE)) begin
            b_sum = b_sum - enms_pkg::SUM_W'(enms_pkg::RING_SIZE);
        end
        a_addr = a_sum[enms_pkg::RING_AW-1:0];
        b_addr = b_sum[enms_pkg::RING_AW-1:0];

        n_s2.center    = r_ctr_mag;
        n_s2.a_ok      = nb_a_ok;
        n_s2.b_ok      = nb_b_ok;
        n_s2.row_end   = r_s1.row_end;
        n_s2.frame_end = r_s1.frame_end;
    end

    // suppression compare
    always_comb begin
        a_val = r_s2.a_ok ? r_nb_a : '0;
        b_val = r_s2.b_ok ? r_nb_b : '0;
        keep  = !((r_s2.center < a_val) || (r_s2.center < b_val));
    end

    // memories: read before write on a shared entry
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_ctr_ram[r_write_slot] <= {i_pix.magnitude, i_pix.direction};
            r_nb_ram[r_write_slot]  <= i_pix.magnitude;
        end
        if (emit) begin
            {r_ctr_mag, r_ctr_dir} <= r_ctr_ram[r_read_slot];
        end
        if (s1_adv) begin
            r_nb_a <= r_nb_ram[a_addr];
            r_nb_b <= r_nb_ram[b_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_s2 <= n_s2;
        end
        if (s2_adv) begin
            r_out_value     <= keep ? r_s2.center : '0;
            r_out_row_end   <= r_s2.row_end;
            r_out_frame_end <= r_s2.frame_end;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w      <= enms_pkg::WIDTH_W'(enms_pkg::RST_WIDTH);
            r_eff_h      <= enms_pkg::IMG_H_W'(enms_pkg::RST_HEIGHT);
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_pending    <= '0;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_eff_w      <= n_eff_w;
            r_eff_h      <= n_eff_h;
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_pending    <= n_pending;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            if (emit) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_edge.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `ENMS_ASSERT_ALWAYS(a_rst_clears, i_clk,
        !i_rst_n |=> !r_s1_valid && !r_s2_valid && !r_out_valid,
        "stages not cleared by reset")
    `ENMS_ASSERT(a_emit_loads, i_clk, i_rst_n,
        emit |=> r_s1_valid, "released pixel lost at center read")
    `ENMS_ASSERT(a_empty_flush, i_clk, i_rst_n,
        flush_acc && (r_pending == '0) |=> !r_s1_valid,
        "flush released a pixel with none pending")
    `ENMS_ASSERT(a_frame_row, i_clk, i_rst_n,
        o_edge.valid && o_edge.frame_end |-> o_edge.row_end, "frame end without row end")

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Edge non-maximum suppression unit testbench
// Drives raster frames of magnitude/direction pixels and flush ticks through
// the unit, predicts each suppressed edge pixel and its row/frame end flags,
// and checks every output transfer in order. A short directed script opens
// the run, then random frames over several geometries, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD    = 10;
    localparam int IDLE_GAP      = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PIXELS = 420;
    localparam int TAIL_PIXELS   = 40;

    localparam logic [enms_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [enms_pkg::MAG_W-1:0] value;
        logic                       row_end;
        logic                       frame_end;
    } t_edge;

    typedef struct {
        logic                       act;
        logic [enms_pkg::MAG_W-1:0] mag;
        logic [enms_pkg::DIR_W-1:0] dir;
        bit                         typed;
        bit                         t_has;
        t_edge                      t_res;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    enms_pix_if  pix_bus ();
    enms_cfg_if  cfg_bus ();
    enms_edge_if edge_bus ();

    edge_non_maximum_suppression_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .i_cfg   (cfg_bus),
        .o_edge  (edge_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // suppression predictor state
    logic [enms_pkg::MAG_W-1:0]   line_mag [enms_pkg::RING_SIZE];
    logic [enms_pkg::DIR_W-1:0]   line_dir [enms_pkg::RING_SIZE];
    int                           wr_ptr, rd_ptr, backlog;
    int                           in_col, in_row, out_col, out_row;
    logic [enms_pkg::IMG_W_W-1:0] geo_width  = enms_pkg::IMG_W_W'(enms_pkg::RST_WIDTH);
    logic [enms_pkg::IMG_H_W-1:0] geo_height = enms_pkg::IMG_H_W'(enms_pkg::RST_HEIGHT);

    t_edge expected_edges [$];
    int    errors        = 0;
    int    cycle_count   = 0;
    int    random_pixels = 0;
    bit    steady        = 1'b0;

    // 3 x 3 frame, then a flat frame of equal magnitudes (ties pass)
    t_script_row script [0:24] = '{
        '{enms_pkg::ACT_FLUSH, 8'd0,   enms_pkg::DIR_HORZ,    1'b1, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd255, enms_pkg::DIR_HORZ,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd0,   enms_pkg::DIR_DIAG_DN, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd170, enms_pkg::DIR_VERT,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_FLUSH, 8'd255, enms_pkg::DIR_DIAG_UP, 1'b1, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd85,  enms_pkg::DIR_DIAG_UP, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd200, enms_pkg::DIR_HORZ,    1'b1, 1'b1,
          '{8'd255, 1'b0, 1'b0}},
        '{enms_pkg::ACT_PIXEL, 8'd200, enms_pkg::DIR_VERT,    1'b1, 1'b1,
          '{8'd0, 1'b0, 1'b0}},
        '{enms_pkg::ACT_PIXEL, 8'd100, enms_pkg::DIR_DIAG_DN, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd1,   enms_pkg::DIR_DIAG_UP, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd254, enms_pkg::DIR_VERT,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_FLUSH, 8'd0,   enms_pkg::DIR_HORZ,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_FLUSH, 8'd0,   enms_pkg::DIR_DIAG_DN, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_FLUSH, 8'd0,   enms_pkg::DIR_VERT,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_FLUSH, 8'd0,   enms_pkg::DIR_DIAG_UP, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_FLUSH, 8'd0,   enms_pkg::DIR_HORZ,    1'b1, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_HORZ,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_DIAG_DN, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_VERT,    1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_DIAG_UP, 1'b0, 1'b0, '0},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_HORZ,    1'b1, 1'b1,
          '{8'd9, 1'b0, 1'b0}},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_DIAG_DN, 1'b1, 1'b1,
          '{8'd9, 1'b0, 1'b0}},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_VERT,    1'b1, 1'b1,
          '{8'd9, 1'b1, 1'b0}},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_DIAG_UP, 1'b1, 1'b1,
          '{8'd9, 1'b0, 1'b0}},
        '{enms_pkg::ACT_PIXEL, 8'd9,   enms_pkg::DIR_HORZ,    1'b1, 1'b1,
          '{8'd9, 1'b0, 1'b0}}
    };

    function automatic int active_width();
        if (geo_width == 0) return 1;
        if (geo_width > enms_pkg::MAX_WIDTH) return enms_pkg::MAX_WIDTH;
        return int'(geo_width);
    endfunction

    function automatic int active_height();
        return (geo_height == 0) ? 1 : int'(geo_height);
    endfunction

    function automatic logic [enms_pkg::MAG_W-1:0] near_mag(int dr, int dc, int w, int h);
        int idx;
        if (dr < 0 && out_row == 0) return '0;
        if (dr > 0 && out_row + 1 >= h) return '0;
        if (dc < 0 && out_col == 0) return '0;
        if (dc > 0 && out_col + 1 >= w) return '0;
        idx = (rd_ptr + enms_pkg::RING_SIZE + dr * w + dc) % enms_pkg::RING_SIZE;
        return line_mag[idx];
    endfunction

    function automatic t_edge release_oldest(int w, int h);
        logic [enms_pkg::MAG_W-1:0] ctr, a, b;
        t_edge                      r;
        ctr = line_mag[rd_ptr];
        a   = '0;
        b   = '0;
        case (line_dir[rd_ptr])
            enms_pkg::DIR_HORZ: begin
                a = near_mag(0, -1, w, h);
                b = near_mag(0, 1, w, h);
            end
            enms_pkg::DIR_DIAG_DN: begin
                a = near_mag(-1, -1, w, h);
                b = near_mag(1, 1, w, h);
            end
            enms_pkg::DIR_VERT: begin
                a = near_mag(-1, 0, w, h);
                b = near_mag(1, 0, w, h);
            end
            enms_pkg::DIR_DIAG_UP: begin
                a = near_mag(-1, 1, w, h);
                b = near_mag(1, -1, w, h);
            end
            default: ;
        endcase
        if (ctr < a || ctr < b) ctr = '0;
        r.value     = ctr;
        r.row_end   = (out_col + 1 >= w);
        r.frame_end = r.row_end && (out_row + 1 >= h);
        if (r.row_end) begin
            out_col = 0;
            out_row = r.frame_end ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
        rd_ptr = (rd_ptr + 1) % enms_pkg::RING_SIZE;
        backlog--;
        return r;
    endfunction

    function automatic bit suppress_step(input logic act,
                                         input logic [enms_pkg::MAG_W-1:0] mag,
                                         input logic [enms_pkg::DIR_W-1:0] dir,
                                         output t_edge res);
        int w, h;
        w   = active_width();
        h   = active_height();
        res = '0;
        if (act == enms_pkg::ACT_PIXEL) begin
            line_mag[wr_ptr] = mag;
            line_dir[wr_ptr] = dir;
            wr_ptr = (wr_ptr + 1) % enms_pkg::RING_SIZE;
            backlog++;
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            if (backlog > w + 1) begin
                res = release_oldest(w, h);
                return 1'b1;
            end
            return 1'b0;
        end
        if (backlog > 0 && in_col == 0 && in_row == 0) begin
            res = release_oldest(w, h);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [enms_pkg::MAG_W-1:0] pick_magnitude();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return enms_pkg::MAG_W'($urandom_range(3));
        if (roll < 40) return '1;
        return enms_pkg::MAG_W'($urandom);
    endfunction

    task automatic send_item(input logic act, input logic [enms_pkg::MAG_W-1:0] mag,
                             input logic [enms_pkg::DIR_W-1:0] dir,
                             output bit made, output t_edge res);
        while (!steady && $urandom_range(99) < 16) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid     <= 1'b1;
        pix_bus.action    <= act;
        pix_bus.magnitude <= mag;
        pix_bus.direction <= dir;
        do @(negedge i_clk); while (!pix_bus.ready);
        made = suppress_step(act, mag, dir, res);
        @(posedge i_clk);
    endtask

    task automatic feed(input logic act, input logic [enms_pkg::MAG_W-1:0] mag,
                        input logic [enms_pkg::DIR_W-1:0] dir);
        bit    made;
        t_edge res;
        send_item(act, mag, dir, made, res);
        if (made) expected_edges.push_back(res);
    endtask

    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    // flush out the tail of a completed frame
    task automatic drain_frame();
        while (backlog > 0 && in_col == 0 && in_row == 0)
            feed(enms_pkg::ACT_FLUSH, enms_pkg::MAG_W'($urandom),
                 enms_pkg::DIR_W'($urandom));
    endtask

    task automatic write_reg(input logic [enms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [enms_pkg::CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(negedge i_clk); while (!cfg_bus.ready);
        case (idx)
            enms_pkg::CFG_IMAGE_WIDTH:  geo_width  = val[enms_pkg::IMG_W_W-1:0];
            enms_pkg::CFG_IMAGE_HEIGHT: geo_height = val[enms_pkg::IMG_H_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [enms_pkg::CFG_DATA_W-1:0] w_data,
                                input logic [enms_pkg::CFG_DATA_W-1:0] h_data,
                                input bit spare);
        drain_frame();
        settle();
        write_reg(enms_pkg::CFG_IMAGE_WIDTH, w_data);
        write_reg(enms_pkg::CFG_IMAGE_HEIGHT, h_data);
        if (spare) write_reg(CFG_SPARE, enms_pkg::CFG_DATA_W'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic stream_frames(input int frames, input int noise_pct);
        int n;
        repeat (frames) begin
            n = active_width() * active_height();
            repeat (n) begin
                if ($urandom_range(99) < noise_pct)
                    feed(enms_pkg::ACT_FLUSH, enms_pkg::MAG_W'($urandom),
                         enms_pkg::DIR_W'($urandom));
                feed(enms_pkg::ACT_PIXEL, pick_magnitude(), enms_pkg::DIR_W'($urandom));
                random_pixels++;
            end
            case ($urandom_range(3))
                0, 1: drain_frame();
                2: begin
                    repeat ($urandom_range(active_width()))
                        feed(enms_pkg::ACT_FLUSH, enms_pkg::MAG_W'($urandom),
                             enms_pkg::DIR_W'($urandom));
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) edge_bus.ready <= steady || ($urandom_range(99) >= 16);

    always @(negedge i_clk) begin : edge_check
        t_edge want;
        if (i_rst_n && edge_bus.valid && edge_bus.ready) begin
            if (expected_edges.size() == 0) begin
                $error("edge transfer with none expected: edge_value %0d",
                       edge_bus.edge_value);
                errors++;
            end else begin
                want = expected_edges.pop_front();
                if (edge_bus.edge_value !== want.value) begin
                    $error("edge_value: expected %0d, got %0d", want.value, edge_bus.edge_value);
                    errors++;
                end
                if (edge_bus.row_end !== want.row_end) begin
                    $error("row_end: expected %0b, got %0b", want.row_end, edge_bus.row_end);
                    errors++;
                end
                if (edge_bus.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end,
                           edge_bus.frame_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        bit    made;
        t_edge got;
        i_rst_n           = 1'b0;
        pix_bus.valid     = 1'b0;
        pix_bus.action    = enms_pkg::ACT_PIXEL;
        pix_bus.magnitude = '0;
        pix_bus.direction = enms_pkg::DIR_HORZ;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = enms_pkg::CFG_IMAGE_WIDTH;
        cfg_bus.data      = '0;
        edge_bus.ready    = 1'b0;
        foreach (line_mag[k]) begin
            line_mag[k] = '0;
            line_dir[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_geometry(16'd3, 16'd3, 1'b0);
        foreach (script[k]) begin
            send_item(script[k].act, script[k].mag, script[k].dir, made, got);
            if (script[k].typed) begin
                if (script[k].t_has) expected_edges.push_back(script[k].t_res);
            end else if (made) begin
                expected_edges.push_back(got);
            end
        end

        // single-pixel frames, then zero registers that count as one
        set_geometry(16'd1, 16'd1, 1'b1);
        stream_frames(20, 10);
        set_geometry(16'd0, 16'd0, 1'b0);
        stream_frames(10, 30);

        // long lines with no idling on either side
        set_geometry(16'd24, 16'd4, 1'b0);
        steady = 1'b1;
        stream_frames(1, 0);
        steady = 1'b0;

        // upper width bits ignored
        set_geometry(16'hF803, 16'd2, 1'b0);
        stream_frames(1, 2);

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            set_geometry(enms_pkg::CFG_DATA_W'($urandom_range(9, 1)),
                         enms_pkg::CFG_DATA_W'($urandom_range(6, 1)), 1'b0);
            stream_frames($urandom_range(3, 1), 8);
        end

        // tallest frame, left open
        set_geometry(enms_pkg::CFG_DATA_W'($urandom_range(4, 1)), 16'hFFFF, 1'b0);
        repeat (TAIL_PIXELS)
            feed(enms_pkg::ACT_PIXEL, pick_magnitude(), enms_pkg::DIR_W'($urandom));

        pix_bus.valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
